### rtl/dlr_pkg.sv
// Shared constants, widths, request codes and state type of the dense layer with ReLU.
package dlr_pkg;

  // Layer dimensions and data width
  localparam int IN_MAX  = 1024;
  localparam int OUT_MAX = 64;
  localparam int DATA_W  = 16;

  // Fixed field and register widths
  localparam int ACC_W          = 48;
  localparam int REQ_W          = 2;
  localparam int SLOT_W         = 16;
  localparam int VALUE_W        = 16;
  localparam int OUT_VALUE_W    = 15;
  localparam int OUT_INDEX_W    = 6;
  localparam int IN_COUNT_W     = 11;
  localparam int OUT_COUNT_W    = 7;
  localparam int CFG_DATA_W     = 11;
  localparam int CFG_IDX_W      = 1;

  localparam logic [IN_COUNT_W-1:0]  IN_COUNT_RESET  = IN_COUNT_W'(784);
  localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_RESET = OUT_COUNT_W'(64);

  // Derived storage widths
  localparam int W_DEPTH = IN_MAX * OUT_MAX;
  localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int POS_W   = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
  localparam int IDX_W   = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
  localparam int NOUT_W  = $clog2(OUT_MAX + 1);
  localparam int NIN_W   = $clog2(IN_MAX + 1);
  localparam int CMP_W   = (NIN_W > IN_COUNT_W) ? NIN_W : IN_COUNT_W;
  localparam int CMPO_W  = (NOUT_W > OUT_COUNT_W) ? NOUT_W : OUT_COUNT_W;

  // Arithmetic widths
  localparam int PROD_W  = 2 * DATA_W;
  localparam int SUM_W   = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
  localparam int BIAS_SHIFT = 8;
  localparam int TOT_W   = ((DATA_W + BIAS_SHIFT > ACC_W) ? DATA_W + BIAS_SHIFT : ACC_W) + 1;
  localparam int FRAC_SHIFT = 12;
  localparam logic [TOT_W-1:0] ROUND_HALF = TOT_W'(2048);
  localparam logic [OUT_VALUE_W-1:0] OUT_SAT = OUT_VALUE_W'(32767);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_WEIGHT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BIAS    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FEATURE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COUNT = 1'd1;

  // Control states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_OUT_RD,
    ST_OUT_SUM,
    ST_OUT_RND,
    ST_OUT_SEND
  } state_t;

endpackage

### rtl/dense_layer_relu.sv
// Top level of the fully connected layer with ReLU: control, MAC pipeline and output stage.
//
// Usage: one input channel (in_valid/in_stall) carries three kinds of transaction
// selected by req_type: a weight write (slot = row*OUT_MAX + column), a bias write
// (slot = output number) and a feature element (Q8.8). A feature element walks the
// weight row of its position through one shared multiply-accumulate unit, one
// weight memory word per cycle, over out_count columns (all OUT_MAX columns on
// the first element of a vector, which also clears every accumulator). After the
// last element of a vector the block emits out_count results on the output channel
// (out_valid/out_stall), in neuron order, each through ST_OUT_RD, ST_OUT_SUM,
// ST_OUT_RND and ST_OUT_SEND, waiting in ST_OUT_SEND while the receiver stalls; the
// last one carries out_last. in_stall is high while a feature or its results are
// in flight. The output register holds its transaction unchanged while out_stall
// is high. Configuration (in_count, out_count) is written through cfg_we,
// cfg_index, cfg_data while the block is idle. Synchronous reset clears the
// control state, the feature position and restores in_count 784, out_count 64;
// weight and bias memories keep undefined contents until written, and there is
// no clearing pass.
module dense_layer_relu (
  clk,
  rst,
  in_valid,
  in_stall,
  req_type,
  slot,
  value,
  out_valid,
  out_stall,
  out_value,
  out_index,
  out_last,
  cfg_we,
  cfg_index,
  cfg_data
);
  input  logic                                 clk;
  input  logic                                 rst;
  input  logic                                 in_valid;
  output logic                                 in_stall;
  input  logic [dlr_pkg::REQ_W-1:0]            req_type;
  input  logic [dlr_pkg::SLOT_W-1:0]           slot;
  input  logic signed [dlr_pkg::VALUE_W-1:0]   value;
  output logic                                 out_valid;
  input  logic                                 out_stall;
  output logic [dlr_pkg::OUT_VALUE_W-1:0]      out_value;
  output logic [dlr_pkg::OUT_INDEX_W-1:0]      out_index;
  output logic                                 out_last;
  input  logic                                 cfg_we;
  input  logic [dlr_pkg::CFG_IDX_W-1:0]        cfg_index;
  input  logic [dlr_pkg::CFG_DATA_W-1:0]       cfg_data;

  // Configuration registers
  logic [dlr_pkg::IN_COUNT_W-1:0]  in_count;
  logic [dlr_pkg::OUT_COUNT_W-1:0] out_count;

  // Control
  dlr_pkg::state_t state, state_next;
  logic in_acc;
  logic feat_acc;
  logic mac_issue;
  logic mac_done;
  logic out_acc;

  // Effective counts
  logic [dlr_pkg::CMP_W-1:0]  nin;
  logic [dlr_pkg::NOUT_W-1:0] nout;

  // Feature position handling
  logic [dlr_pkg::POS_W-1:0] pos;
  logic [dlr_pkg::CMP_W-1:0] pos_eff;
  logic [dlr_pkg::CMP_W-1:0] pos_inc;

  // Per-feature registers
  logic signed [dlr_pkg::DATA_W-1:0] x;
  logic [dlr_pkg::WA_W-1:0]   row_base;
  logic                       first;
  logic                       emit;
  logic [dlr_pkg::NOUT_W-1:0] issue_cnt;
  logic [dlr_pkg::NOUT_W-1:0] issue_len;

  // MAC pipeline
  logic                              v1, v2;
  logic [dlr_pkg::IDX_W-1:0]         j1, j2;
  logic signed [dlr_pkg::PROD_W-1:0] prod;
  logic signed [dlr_pkg::ACC_W-1:0]  acc1;
  logic signed [dlr_pkg::ACC_W-1:0]  acc_in;
  logic signed [dlr_pkg::SUM_W-1:0]  sum;
  logic [dlr_pkg::SUM_W-dlr_pkg::ACC_W:0] sum_top;
  logic signed [dlr_pkg::ACC_W-1:0]  sum_sat;

  // Output path
  logic [dlr_pkg::NOUT_W-1:0]        oj;
  logic signed [dlr_pkg::TOT_W-1:0]  total;
  logic signed [dlr_pkg::TOT_W-1:0]  bias_ext;
  logic [dlr_pkg::TOT_W-1:0]         rnd;
  logic [dlr_pkg::TOT_W-1:0]         rnd_shift;

  // Memory ports
  logic                        w_we;
  logic [dlr_pkg::WA_W-1:0]    w_waddr;
  logic [dlr_pkg::DATA_W-1:0]  w_wdata;
  logic                        w_re;
  logic [dlr_pkg::WA_W-1:0]    w_raddr;
  logic [dlr_pkg::DATA_W-1:0]  w_rdata;
  logic                        b_we;
  logic                        b_re;
  logic [dlr_pkg::DATA_W-1:0]  b_rdata;
  logic                        a_we;
  logic [dlr_pkg::IDX_W-1:0]   a_waddr;
  logic [dlr_pkg::ACC_W-1:0]   a_wdata;
  logic                        a_re;
  logic [dlr_pkg::IDX_W-1:0]   a_raddr;
  logic [dlr_pkg::ACC_W-1:0]   a_rdata;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      in_count  <= dlr_pkg::IN_COUNT_RESET;
      out_count <= dlr_pkg::OUT_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dlr_pkg::REG_IN_COUNT:  in_count  <= cfg_data;
        dlr_pkg::REG_OUT_COUNT: out_count <= cfg_data[dlr_pkg::OUT_COUNT_W-1:0];
      endcase
    end
  end

  // Clamp counts into their legal ranges
  always_comb begin
    if (in_count == '0) begin
      nin = dlr_pkg::CMP_W'(1);
    end else if (dlr_pkg::CMP_W'(in_count) > dlr_pkg::CMP_W'(dlr_pkg::IN_MAX)) begin
      nin = dlr_pkg::CMP_W'(dlr_pkg::IN_MAX);
    end else begin
      nin = dlr_pkg::CMP_W'(in_count);
    end
    if (out_count == '0) begin
      nout = dlr_pkg::NOUT_W'(1);
    end else if (dlr_pkg::CMPO_W'(out_count) > dlr_pkg::CMPO_W'(dlr_pkg::OUT_MAX)) begin
      nout = dlr_pkg::NOUT_W'(dlr_pkg::OUT_MAX);
    end else begin
      nout = dlr_pkg::NOUT_W'(out_count);
    end
  end

  // Position of this feature within its vector
  always_comb begin
    pos_eff = (dlr_pkg::CMP_W'(pos) >= nin) ? '0 : dlr_pkg::CMP_W'(pos);
    pos_inc = pos_eff + dlr_pkg::CMP_W'(1);
  end

  // Handshake qualifiers
  assign in_acc    = in_valid && !in_stall;
  assign feat_acc  = in_acc && (req_type == dlr_pkg::REQ_FEATURE);
  assign mac_done  = (state == dlr_pkg::ST_MAC) && !mac_issue && !v1 && !v2;
  assign out_acc   = out_valid && !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dlr_pkg::ST_IDLE: begin
        if (feat_acc) state_next = dlr_pkg::ST_MAC;
      end
      dlr_pkg::ST_MAC: begin
        if (mac_done) state_next = emit ? dlr_pkg::ST_OUT_RD : dlr_pkg::ST_IDLE;
      end
      dlr_pkg::ST_OUT_RD:  state_next = dlr_pkg::ST_OUT_SUM;
      dlr_pkg::ST_OUT_SUM: state_next = dlr_pkg::ST_OUT_RND;
      dlr_pkg::ST_OUT_RND: state_next = dlr_pkg::ST_OUT_SEND;
      dlr_pkg::ST_OUT_SEND: begin
        if (!out_stall) state_next = out_last ? dlr_pkg::ST_IDLE : dlr_pkg::ST_OUT_RD;
      end
      default: state_next = dlr_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall  = (state != dlr_pkg::ST_IDLE);
    out_valid = (state == dlr_pkg::ST_OUT_SEND);
    mac_issue = (state == dlr_pkg::ST_MAC) && (issue_cnt != issue_len);
    b_re      = (state == dlr_pkg::ST_OUT_RD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Feature setup and position tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      issue_cnt <= '0;
      issue_len <= '0;
      emit      <= 1'b0;
      first     <= 1'b0;
    end else if (feat_acc) begin
      pos       <= (pos_inc >= nin) ? '0 : dlr_pkg::POS_W'(pos_inc);
      emit      <= (pos_inc >= nin);
      first     <= (pos_eff == '0);
      issue_cnt <= '0;
      issue_len <= (pos_eff == '0) ? dlr_pkg::NOUT_W'(dlr_pkg::OUT_MAX) : nout;
    end else if (mac_issue) begin
      issue_cnt <= issue_cnt + dlr_pkg::NOUT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (feat_acc) begin
      x        <= dlr_pkg::DATA_W'($unsigned(value));
      row_base <= dlr_pkg::WA_W'(pos_eff[dlr_pkg::POS_W-1:0])
                  * dlr_pkg::WA_W'(dlr_pkg::OUT_MAX);
    end
  end

  // Store writes taken straight from the input channel
  always_comb begin
    w_we    = in_acc && (req_type == dlr_pkg::REQ_WEIGHT)
              && (32'(slot) < 32'(dlr_pkg::W_DEPTH));
    b_we    = in_acc && (req_type == dlr_pkg::REQ_BIAS)
              && (32'(slot) < 32'(dlr_pkg::OUT_MAX));
    w_waddr = dlr_pkg::WA_W'(slot);
    w_wdata = dlr_pkg::DATA_W'($unsigned(value));
  end

  // Read addresses: MAC walk or output walk
  always_comb begin
    w_re    = mac_issue;
    w_raddr = row_base + dlr_pkg::WA_W'(issue_cnt);
    a_re    = mac_issue || (state == dlr_pkg::ST_OUT_RD);
    a_raddr = (state == dlr_pkg::ST_MAC) ? issue_cnt[dlr_pkg::IDX_W-1:0]
                                         : oj[dlr_pkg::IDX_W-1:0];
  end

  // MAC pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= mac_issue;
      v2 <= v1;
    end
  end

  // Stage 1: multiply, capture accumulator
  always_ff @(posedge clk) begin
    if (mac_issue) begin
      j1 <= issue_cnt[dlr_pkg::IDX_W-1:0];
    end
    if (v1) begin
      prod <= x * $signed(w_rdata);
      acc1 <= $signed(a_rdata);
      j2   <= j1;
    end
  end

  // Stage 2: add with saturation, write back
  always_comb begin
    acc_in  = first ? '0 : acc1;
    sum     = dlr_pkg::SUM_W'(acc_in) + dlr_pkg::SUM_W'(prod);
    sum_top = sum[dlr_pkg::SUM_W-1:dlr_pkg::ACC_W-1];
    if ((sum_top != '0) && (sum_top != '1)) begin
      sum_sat = sum[dlr_pkg::SUM_W-1] ? {1'b1, {(dlr_pkg::ACC_W-1){1'b0}}}
                                      : {1'b0, {(dlr_pkg::ACC_W-1){1'b1}}};
    end else begin
      sum_sat = sum[dlr_pkg::ACC_W-1:0];
    end
    a_we    = v2;
    a_waddr = j2;
    // first element clears the columns beyond the ones in use
    if (first && (dlr_pkg::NOUT_W'(j2) >= nout)) begin
      a_wdata = '0;
    end else begin
      a_wdata = sum_sat;
    end
  end

  // Output walk: bias alignment, ReLU, rounding, saturation
  always_comb begin
    bias_ext  = dlr_pkg::TOT_W'($signed(b_rdata));
    rnd       = $unsigned(total) + dlr_pkg::ROUND_HALF;
    rnd_shift = rnd >> dlr_pkg::FRAC_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oj <= '0;
    end else if (feat_acc) begin
      oj <= '0;
    end else if (out_acc) begin
      oj <= oj + dlr_pkg::NOUT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == dlr_pkg::ST_OUT_SUM) begin
      total <= dlr_pkg::TOT_W'($signed(a_rdata)) + (bias_ext <<< dlr_pkg::BIAS_SHIFT);
    end
    if (state == dlr_pkg::ST_OUT_RND) begin
      if (total[dlr_pkg::TOT_W-1]) begin
        out_value <= '0;
      end else if (rnd_shift > dlr_pkg::TOT_W'(dlr_pkg::OUT_SAT)) begin
        out_value <= dlr_pkg::OUT_SAT;
      end else begin
        out_value <= rnd_shift[dlr_pkg::OUT_VALUE_W-1:0];
      end
      out_index <= dlr_pkg::OUT_INDEX_W'(oj);
      out_last  <= (oj == nout - dlr_pkg::NOUT_W'(1));
    end
  end

  // Weight store
  dlr_ram #(
    .WIDTH(dlr_pkg::DATA_W),
    .DEPTH(dlr_pkg::W_DEPTH)
  ) u_weight_ram (
    .clk  (clk),
    .we   (w_we),
    .waddr(w_waddr),
    .wdata(w_wdata),
    .re   (w_re),
    .raddr(w_raddr),
    .rdata(w_rdata)
  );

  // Bias store
  dlr_ram #(
    .WIDTH(dlr_pkg::DATA_W),
    .DEPTH(dlr_pkg::OUT_MAX)
  ) u_bias_ram (
    .clk  (clk),
    .we   (b_we),
    .waddr(slot[dlr_pkg::IDX_W-1:0]),
    .wdata(w_wdata),
    .re   (b_re),
    .raddr(oj[dlr_pkg::IDX_W-1:0]),
    .rdata(b_rdata)
  );

  // Accumulator store
  dlr_ram #(
    .WIDTH(dlr_pkg::ACC_W),
    .DEPTH(dlr_pkg::OUT_MAX)
  ) u_acc_ram (
    .clk  (clk),
    .we   (a_we),
    .waddr(a_waddr),
    .wdata(a_wdata),
    .re   (a_re),
    .raddr(a_raddr),
    .rdata(a_rdata)
  );

endmodule

### rtl/dlr_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module dlr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  clk,
  we,
  waddr,
  wdata,
  re,
  raddr,
  rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             we;
  input  logic [AW-1:0]    waddr;
  input  logic [WIDTH-1:0] wdata;
  input  logic             re;
  input  logic [AW-1:0]    raddr;
  output logic [WIDTH-1:0] rdata;

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
